### hw/rtl/bps_pkg.sv
// Shared types, constants and helper functions for the battery power supervisor.
package bps_pkg;

  localparam int unsigned MvW    = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MvW-1:0]    PercentLowMv  = 14'd6400;
  localparam logic [MvW-1:0]    PercentHighMv = 14'd8400;
  localparam logic [PctW-1:0]   PercentFull   = 7'd100;
  localparam logic [CountW-1:0] CountMax      = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLowLevel      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCriticalLevel = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCheckInterval = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlinkPeriod   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBlinkOn       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLongPress     = 3'd5;

  typedef enum logic [1:0] {
    OpTick          = 2'd0,
    OpSetMode       = 2'd1,
    OpReqShutdown   = 2'd2,
    OpForceShutdown = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ModeNormal   = 3'd0,
    ModeStandby  = 3'd1,
    ModeTransmit = 3'd2,
    ModeReceive  = 3'd3,
    ModeShutdown = 3'd4
  } mode_e;

  typedef struct packed {
    logic [MvW-1:0]    low_level_mv;
    logic [MvW-1:0]    critical_level_mv;
    logic [CountW-1:0] check_interval_ticks;
    logic [CountW-1:0] blink_period_ticks;
    logic [CountW-1:0] blink_on_ticks;
    logic [CountW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    op_e            operation;
    logic           button_down;
    logic [MvW-1:0] battery_sample_mv;
    logic [2:0]     new_mode;
  } item_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic            mode_changed;
    logic [2:0]      previous_mode;
    logic            shutdown_latched;
    logic            battery_low;
    logic            battery_critical;
    logic [MvW-1:0]  battery_level_mv;
    logic [PctW-1:0] battery_percent;
    logic            red_lamp;
    logic            green_lamp;
  } result_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? v : v + 16'd1;
  endfunction

  // Percent over the 2000 mV span is (level - 6400) / 20. The quotient is taken
  // as a shift by two and then a multiply by 205/1024, which is exact for the
  // 9-bit values that remain.
  function automatic logic [PctW-1:0] percent_of(input logic [MvW-1:0] mv);
    logic [MvW-1:0] diff;
    logic [16:0]    prod;
    diff = mv - PercentLowMv;
    prod = {8'd0, diff[10:2]} * 17'd205;
    if (mv <= PercentLowMv) begin
      percent_of = '0;
    end else if (mv >= PercentHighMv) begin
      percent_of = PercentFull;
    end else begin
      percent_of = prod[16:10];
    end
  endfunction

endpackage

### hw/rtl/bps_cfg_regs.sv
// Configuration register file, written through a plain indexed write port.
module bps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]  cfg_data_i,
  output bps_pkg::cfg_t                 cfg_o
);
  import bps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLowLevel:      cfg_d.low_level_mv         = cfg_data_i[MvW-1:0];
        CfgCriticalLevel: cfg_d.critical_level_mv    = cfg_data_i[MvW-1:0];
        CfgCheckInterval: cfg_d.check_interval_ticks = cfg_data_i;
        CfgBlinkPeriod:   cfg_d.blink_period_ticks   = cfg_data_i;
        CfgBlinkOn:       cfg_d.blink_on_ticks       = cfg_data_i;
        CfgLongPress:     cfg_d.long_press_ticks     = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_level_mv         <= 14'd6800;
      cfg_q.critical_level_mv    <= 14'd6400;
      cfg_q.check_interval_ticks <= 16'd1000;
      cfg_q.blink_period_ticks   <= 16'd5000;
      cfg_q.blink_on_ticks       <= 16'd100;
      cfg_q.long_press_ticks     <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/bps_core.sv
// Supervisor state and the single-pass update that turns one item into one result.
module bps_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  bps_pkg::item_t   item_i,
  input  bps_pkg::cfg_t    cfg_i,
  output bps_pkg::result_t result_o
);
  import bps_pkg::*;

  mode_e             mode_q, mode_d;
  logic              shut_q, shut_d;
  logic              low_q, low_d;
  logic [MvW-1:0]    level_q, level_d;
  logic [CountW-1:0] check_q, check_d;
  logic [CountW-1:0] blink_q, blink_d;
  logic [CountW-1:0] press_q, press_d;
  logic              was_down_q, was_down_d;
  logic              red_q, red_d;
  logic              green_q, green_d;
  logic              changed;
  logic [CountW-1:0] check_elapsed;
  logic [CountW-1:0] blink_elapsed;
  logic [CountW-1:0] press_next;

  assign check_elapsed = sat_inc(check_q);
  assign blink_elapsed = sat_inc(blink_q);
  assign press_next    = sat_inc(press_q);

  always_comb begin
    mode_d     = mode_q;
    shut_d     = shut_q;
    low_d      = low_q;
    level_d    = level_q;
    check_d    = check_q;
    blink_d    = blink_q;
    press_d    = press_q;
    was_down_d = was_down_q;
    red_d      = red_q;
    green_d    = green_q;
    changed    = 1'b0;

    case (item_i.operation)
      OpTick: begin
        // Battery capture once the interval has elapsed.
        if (check_elapsed >= cfg_i.check_interval_ticks) begin
          check_d = '0;
          level_d = item_i.battery_sample_mv;
          low_d   = item_i.battery_sample_mv < cfg_i.low_level_mv;
          if (low_d && !low_q) begin
            red_d = 1'b1;
          end
        end else begin
          check_d = check_elapsed;
        end

        // Short green flash once per period while in standby.
        if (mode_q == ModeStandby) begin
          if (blink_elapsed >= cfg_i.blink_period_ticks) begin
            green_d = 1'b1;
            blink_d = '0;
          end else begin
            if (blink_elapsed >= cfg_i.blink_on_ticks) begin
              green_d = 1'b0;
            end
            blink_d = blink_elapsed;
          end
        end

        // Long press detection; the first pressed tick only arms the count.
        if (item_i.button_down) begin
          if (!was_down_q) begin
            press_d = '0;
          end else begin
            press_d = press_next;
            if (press_next >= cfg_i.long_press_ticks) begin
              shut_d = 1'b1;
            end
          end
        end else begin
          press_d = '0;
        end
        was_down_d = item_i.button_down;

        if (level_d < cfg_i.critical_level_mv) begin
          shut_d = 1'b1;
        end
      end
      OpSetMode: begin
        if (item_i.new_mode <= ModeShutdown && item_i.new_mode != mode_q) begin
          changed = 1'b1;
          mode_d  = mode_e'(item_i.new_mode);
          case (mode_d)
            ModeStandby:  blink_d = '0;
            ModeTransmit: red_d   = 1'b1;
            ModeReceive:  green_d = 1'b1;
            ModeShutdown: shut_d  = 1'b1;
            default:      changed = 1'b1;
          endcase
        end
      end
      OpReqShutdown: begin
        shut_d = 1'b1;
      end
      OpForceShutdown: begin
        shut_d = 1'b1;
        mode_d = ModeShutdown;
      end
      default: begin
        shut_d = shut_q;
      end
    endcase
  end

  always_comb begin
    result_o.mode             = mode_d;
    result_o.mode_changed     = changed;
    result_o.previous_mode    = mode_q;
    result_o.shutdown_latched = shut_d;
    result_o.battery_low      = low_d;
    result_o.battery_critical = level_d < cfg_i.critical_level_mv;
    result_o.battery_level_mv = level_d;
    result_o.battery_percent  = percent_of(level_d);
    result_o.red_lamp         = red_d;
    result_o.green_lamp       = green_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeNormal;
      shut_q     <= 1'b0;
      low_q      <= 1'b0;
      level_q    <= PercentHighMv;
      check_q    <= '0;
      blink_q    <= '0;
      press_q    <= '0;
      was_down_q <= 1'b0;
      red_q      <= 1'b0;
      green_q    <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      shut_q     <= shut_d;
      low_q      <= low_d;
      level_q    <= level_d;
      check_q    <= check_d;
      blink_q    <= blink_d;
      press_q    <= press_d;
      was_down_q <= was_down_d;
      red_q      <= red_d;
      green_q    <= green_d;
    end
  end

endmodule

### hw/rtl/battery_power_supervisor.sv
// Top level of the battery power supervisor: input register, core and result register.
//
// The input channel carries one transaction per item: a 1 ms tick (with the
// button level and a battery converter reading) or a software event (set mode,
// request shutdown, force shutdown). Every item yields exactly one result
// transaction on the output channel, in order. Both channels use valid and
// stall; a transaction completes at a rising edge with valid high and stall low.
//
// An accepted item waits in the input register while the core works out the
// new state and the result in one combinational pass; the edge on which it
// fires commits the state and loads the result register, which then offers
// the result. One item per cycle is sustained while the receiver does not
// stall. When it stalls, the result register holds its transaction and the
// input stall rises only once the input register is also full; a held result
// never stops an item entering an empty input register. Reset (rst_ni low,
// asynchronous) empties both registers, returns the state to normal mode with
// a full 8400 mV battery level and loads the default configuration.
// Configuration writes take effect at the next edge; the user must make them
// only while no transaction is in flight, and the block does not enforce this.
module battery_power_supervisor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic                          button_down_i,
  input  logic [bps_pkg::MvW-1:0]       battery_sample_mv_i,
  input  logic [2:0]                    new_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    mode_o,
  output logic                          mode_changed_o,
  output logic [2:0]                    previous_mode_o,
  output logic                          shutdown_latched_o,
  output logic                          battery_low_o,
  output logic                          battery_critical_o,
  output logic [bps_pkg::MvW-1:0]       battery_level_mv_o,
  output logic [bps_pkg::PctW-1:0]      battery_percent_o,
  output logic                          red_lamp_o,
  output logic                          green_lamp_o
);
  import bps_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    fire;
  logic    in_accept;

  bps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register can take a new value when empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? fire : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.operation         <= op_e'(operation_i);
      item_q.button_down       <= button_down_i;
      item_q.battery_sample_mv <= battery_sample_mv_i;
      item_q.new_mode          <= new_mode_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  bps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  assign out_valid_o        = out_valid_q;
  assign mode_o             = res_q.mode;
  assign mode_changed_o     = res_q.mode_changed;
  assign previous_mode_o    = res_q.previous_mode;
  assign shutdown_latched_o = res_q.shutdown_latched;
  assign battery_low_o      = res_q.battery_low;
  assign battery_critical_o = res_q.battery_critical;
  assign battery_level_mv_o = res_q.battery_level_mv;
  assign battery_percent_o  = res_q.battery_percent;
  assign red_lamp_o         = res_q.red_lamp;
  assign green_lamp_o       = res_q.green_lamp;

endmodule

### hw/rtl/bps_checker.sv
// Port-level checker for the battery power supervisor, bound to the top level.
module bps_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    mode_o,
  input logic                          mode_changed_o,
  input logic [2:0]                    previous_mode_o,
  input logic                          shutdown_latched_o,
  input logic [bps_pkg::MvW-1:0]       battery_level_mv_o,
  input logic [bps_pkg::PctW-1:0]      battery_percent_o
);
  import bps_pkg::*;

  // A stalled result transaction stays in place with its mode, level and shutdown flag unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o)
      && $stable(battery_level_mv_o) && $stable(shutdown_latched_o))
    else $error("stalled result changed");

  // Percent follows the reported level at both ends of the span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (battery_percent_o <= PercentFull)
      && ((battery_level_mv_o < PercentHighMv) || (battery_percent_o == PercentFull))
      && ((battery_level_mv_o > PercentLowMv) || (battery_percent_o == '0)))
    else $error("battery percent inconsistent with level");

  // A reported mode change always differs from the mode it left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_changed_o |-> mode_o != previous_mode_o)
    else $error("mode change reported without a change");

  // Shutdown mode can only be reached with the shutdown request latched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == ModeShutdown) |-> shutdown_latched_o)
    else $error("shutdown mode without latched request");

endmodule

bind battery_power_supervisor bps_port_checker u_bps_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .mode_o             (mode_o),
  .mode_changed_o     (mode_changed_o),
  .previous_mode_o    (previous_mode_o),
  .shutdown_latched_o (shutdown_latched_o),
  .battery_level_mv_o (battery_level_mv_o),
  .battery_percent_o  (battery_percent_o)
);

### tb/sv/bps_checker.sv
// Checker for the battery power supervisor: follows both channels, predicts each status and compares.
`timescale 1ns / 1ps
module bps_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [1:0]                   operation_i,
  input  logic                         button_down_i,
  input  logic [bps_pkg::MvW-1:0]      battery_sample_mv_i,
  input  logic [2:0]                   new_mode_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [2:0]                   mode_i,
  input  logic                         mode_changed_i,
  input  logic [2:0]                   previous_mode_i,
  input  logic                         shutdown_latched_i,
  input  logic                         battery_low_i,
  input  logic                         battery_critical_i,
  input  logic [bps_pkg::MvW-1:0]      battery_level_mv_i,
  input  logic [bps_pkg::PctW-1:0]     battery_percent_i,
  input  logic                         red_lamp_i,
  input  logic                         green_lamp_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import bps_pkg::*;

  // Settings as last written.
  logic [MvW-1:0]    low_mv, crit_mv;
  logic [CountW-1:0] check_ivl, blink_per, blink_on, press_len;

  // Predicted supervisor state.
  mode_e             mode_q;
  logic              shut_q, low_q, held_q, red_q, green_q;
  logic [MvW-1:0]    level_q;
  logic [CountW-1:0] check_cnt, blink_cnt, press_cnt;

  result_t     status_due[$];
  int unsigned seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    seen         = 0;
  end

  function automatic void restore_defaults();
    low_mv    = 14'd6800;
    crit_mv   = 14'd6400;
    check_ivl = 16'd1000;
    blink_per = 16'd5000;
    blink_on  = 16'd100;
    press_len = 16'd2000;
    mode_q    = ModeNormal;
    shut_q    = 1'b0;
    low_q     = 1'b0;
    held_q    = 1'b0;
    red_q     = 1'b0;
    green_q   = 1'b0;
    level_q   = PercentHighMv;
    check_cnt = '0;
    blink_cnt = '0;
    press_cnt = '0;
    status_due.delete();
  endfunction

  function automatic void apply_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CfgLowLevel:      low_mv    = val[MvW-1:0];
      CfgCriticalLevel: crit_mv   = val[MvW-1:0];
      CfgCheckInterval: check_ivl = val;
      CfgBlinkPeriod:   blink_per = val;
      CfgBlinkOn:       blink_on  = val;
      CfgLongPress:     press_len = val;
      default: ;
    endcase
  endfunction

  // Counters stop at all ones instead of wrapping.
  function automatic logic [CountW-1:0] count_up(logic [CountW-1:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  function automatic logic [PctW-1:0] charge_percent(logic [MvW-1:0] mv);
    int unsigned span;
    span = PercentHighMv - PercentLowMv;
    if (mv <= PercentLowMv) return '0;
    if (mv >= PercentHighMv) return 7'd100;
    return 7'((int'(mv) - int'(PercentLowMv)) * 100 / span);
  endfunction

  function automatic result_t supervise_item(op_e op, logic btn, logic [MvW-1:0] sample,
                                             logic [2:0] nm);
    result_t           r;
    mode_e             prior;
    logic              changed;
    logic              was_low;
    logic [CountW-1:0] step;
    prior   = mode_q;
    changed = 1'b0;
    case (op)
      OpTick: begin
        // Battery capture first, then the standby blink, the button and the
        // critical check against whatever level is now held.
        step = count_up(check_cnt);
        if (step >= check_ivl) begin
          was_low   = low_q;
          check_cnt = '0;
          level_q   = sample;
          low_q     = level_q < low_mv;
          if (low_q && !was_low) red_q = 1'b1;
        end else begin
          check_cnt = step;
        end
        if (mode_q == ModeStandby) begin
          step = count_up(blink_cnt);
          if (step >= blink_per) begin
            green_q   = 1'b1;
            blink_cnt = '0;
          end else begin
            if (step >= blink_on) green_q = 1'b0;
            blink_cnt = step;
          end
        end
        if (btn) begin
          if (!held_q) begin
            press_cnt = '0;
          end else begin
            press_cnt = count_up(press_cnt);
            if (press_cnt >= press_len) shut_q = 1'b1;
          end
        end else begin
          press_cnt = '0;
        end
        held_q = btn;
        if (level_q < crit_mv) shut_q = 1'b1;
      end
      OpSetMode: begin
        if (nm <= ModeShutdown && nm != mode_q) begin
          changed = 1'b1;
          mode_q  = mode_e'(nm);
          case (mode_q)
            ModeStandby:  blink_cnt = '0;
            ModeTransmit: red_q     = 1'b1;
            ModeReceive:  green_q   = 1'b1;
            ModeShutdown: shut_q    = 1'b1;
            default: ;
          endcase
        end
      end
      OpReqShutdown: shut_q = 1'b1;
      default: begin
        shut_q = 1'b1;
        mode_q = ModeShutdown;
      end
    endcase
    r.mode             = mode_q;
    r.mode_changed     = changed;
    r.previous_mode    = prior;
    r.shutdown_latched = shut_q;
    r.battery_low      = low_q;
    r.battery_critical = level_q < crit_mv;
    r.battery_level_mv = level_q;
    r.battery_percent  = charge_percent(level_q);
    r.red_lamp         = red_q;
    r.green_lamp       = green_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("bps_checker: status %0d: %s", seen, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic compare_status();
    result_t want;
    if (status_due.size() == 0) begin
      report_mismatch("transaction with no item outstanding");
    end else begin
      want = status_due.pop_front();
      check_field("mode", 16'(mode_i), 16'(want.mode));
      check_field("mode_changed", 16'(mode_changed_i), 16'(want.mode_changed));
      check_field("previous_mode", 16'(previous_mode_i), 16'(want.previous_mode));
      check_field("shutdown_latched", 16'(shutdown_latched_i), 16'(want.shutdown_latched));
      check_field("battery_low", 16'(battery_low_i), 16'(want.battery_low));
      check_field("battery_critical", 16'(battery_critical_i), 16'(want.battery_critical));
      check_field("battery_level_mv", 16'(battery_level_mv_i), 16'(want.battery_level_mv));
      check_field("battery_percent", 16'(battery_percent_i), 16'(want.battery_percent));
      check_field("red_lamp", 16'(red_lamp_i), 16'(want.red_lamp));
      check_field("green_lamp", 16'(green_lamp_i), 16'(want.green_lamp));
    end
    seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_defaults();
    end else begin
      if (cfg_we_i) apply_setting(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        status_due.push_back(supervise_item(op_e'(operation_i), button_down_i,
                                            battery_sample_mv_i, new_mode_i));
      end
      if (out_valid_i && !out_stall_i) compare_status();
    end
    pending_o = status_due.size();
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the battery power supervisor: stimulus, result sink and verdict.
`timescale 1ns / 1ps
module tb_top;
  import bps_pkg::*;

  // Mode codes outside the defined set; a set-mode event carrying one of
  // these must be ignored.
  localparam logic [2:0] ModeUnusedLow  = 3'd5;
  localparam logic [2:0] ModeUnusedHigh = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          operation_i;
  logic                button_down_i;
  logic [MvW-1:0]      battery_sample_mv_i;
  logic [2:0]          new_mode_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          mode_o;
  logic                mode_changed_o;
  logic [2:0]          previous_mode_o;
  logic                shutdown_latched_o;
  logic                battery_low_o;
  logic                battery_critical_o;
  logic [MvW-1:0]      battery_level_mv_o;
  logic [PctW-1:0]     battery_percent_o;
  logic                red_lamp_o;
  logic                green_lamp_o;

  int unsigned fails;
  int unsigned pending;

  // Gap insertion on the sending and the receiving side, chosen per phase.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  always #4 clk_i = ~clk_i;

  battery_power_supervisor DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .button_down_i       (button_down_i),
    .battery_sample_mv_i (battery_sample_mv_i),
    .new_mode_i          (new_mode_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mode_o              (mode_o),
    .mode_changed_o      (mode_changed_o),
    .previous_mode_o     (previous_mode_o),
    .shutdown_latched_o  (shutdown_latched_o),
    .battery_low_o       (battery_low_o),
    .battery_critical_o  (battery_critical_o),
    .battery_level_mv_o  (battery_level_mv_o),
    .battery_percent_o   (battery_percent_o),
    .red_lamp_o          (red_lamp_o),
    .green_lamp_o        (green_lamp_o)
  );

  bps_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .operation_i         (operation_i),
    .button_down_i       (button_down_i),
    .battery_sample_mv_i (battery_sample_mv_i),
    .new_mode_i          (new_mode_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mode_i              (mode_o),
    .mode_changed_i      (mode_changed_o),
    .previous_mode_i     (previous_mode_o),
    .shutdown_latched_i  (shutdown_latched_o),
    .battery_low_i       (battery_low_o),
    .battery_critical_i  (battery_critical_o),
    .battery_level_mv_i  (battery_level_mv_o),
    .battery_percent_i   (battery_percent_o),
    .red_lamp_i          (red_lamp_o),
    .green_lamp_i        (green_lamp_o),
    .fail_count_o        (fails),
    .pending_o           (pending)
  );

  // Offers one item as a transaction. The task is entered and left at a
  // falling edge. Valid is only lowered when a gap is drawn, so a valid that
  // stays high for back-to-back transactions is never dropped and raised in
  // the same step.
  task automatic send_item(input op_e op, input logic btn, input logic [MvW-1:0] mv,
                           input logic [2:0] nm);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i         <= op;
    button_down_i       <= btn;
    battery_sample_mv_i <= mv;
    new_mode_i          <= nm;
    in_valid_i          <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until every status has come back. Each
  // item yields a status, so an empty checker queue means the block is idle;
  // a further wait then lets its two-stage pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic task_write(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
  endtask

  // Writes all six registers back to back; the write enable stays high
  // across the burst and drops once at its end.
  task automatic load_settings(input logic [15:0] lo, input logic [15:0] crit,
                               input logic [15:0] ivl, input logic [15:0] per,
                               input logic [15:0] lit, input logic [15:0] lp);
    task_write(CfgLowLevel, lo);
    task_write(CfgCriticalLevel, crit);
    task_write(CfgCheckInterval, ivl);
    task_write(CfgBlinkPeriod, per);
    task_write(CfgBlinkOn, lit);
    task_write(CfgLongPress, lp);
    cfg_we_i <= 1'b0;
  endtask

  // Result sink: before each status it draws a random stall when idling is
  // enabled, then takes the next transaction. The stall is driven only at
  // falling edges, and raised only when a nonzero hold is drawn.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = rx_idle ? $urandom_range(0, 9) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Hard limit: far above the slowest correct run of about two thousand
  // items with worst-case gaps on both sides.
  initial begin
    #2000000;
    $display("battery_power_supervisor: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned r;
    logic [15:0] lo, crit, ivl, per, lit, lp;
    logic        held;
    op_e         op;
    logic [MvW-1:0] mv;
    logic [2:0]  nm;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CfgLowLevel;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    operation_i         = OpTick;
    button_down_i       = 1'b0;
    battery_sample_mv_i = '0;
    new_mode_i          = ModeNormal;
    held                = 1'b0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // With the reset settings a tick captures nothing for a thousand ticks,
    // so the reading must not show up. An unused mode code and a request for
    // the present mode change nothing.
    send_item(OpTick, 1'b0, 14'd0, ModeNormal);
    send_item(OpSetMode, 1'b0, 14'd0, ModeUnusedHigh);
    send_item(OpSetMode, 1'b0, 14'd0, ModeNormal);
    drain();

    // Capture on every tick, a short blink and a short long press.
    load_settings(16'd6800, 16'd6400, 16'd1, 16'd3, 16'd1, 16'd2);

    // Levels at the edges of the percent ramp and around both thresholds;
    // dropping below the low level lights the red lamp.
    send_item(OpTick, 1'b0, 14'd16383, ModeNormal);
    send_item(OpTick, 1'b0, 14'd8400, ModeNormal);
    send_item(OpTick, 1'b0, 14'd8399, ModeNormal);
    send_item(OpTick, 1'b0, 14'd6401, ModeNormal);
    send_item(OpTick, 1'b0, 14'd6800, ModeNormal);
    send_item(OpTick, 1'b0, 14'd6799, ModeNormal);

    // Standby: the green lamp goes out after the on time and lights again
    // when the blink period has run.
    send_item(OpSetMode, 1'b0, 14'd0, ModeStandby);
    send_item(OpTick, 1'b0, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b0, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b0, 14'd7000, ModeNormal);
    send_item(OpSetMode, 1'b0, 14'd0, ModeTransmit);
    send_item(OpSetMode, 1'b0, 14'd0, ModeReceive);
    send_item(OpSetMode, 1'b0, 14'd0, ModeUnusedLow);

    // A release in the middle restarts the press count; the held run after
    // it then latches the shutdown request.
    send_item(OpTick, 1'b1, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b0, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b1, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b1, 14'd7000, ModeNormal);
    send_item(OpTick, 1'b1, 14'd6400, ModeNormal);

    // Critical level, empty reading, then the software shutdown paths.
    send_item(OpTick, 1'b0, 14'd6399, ModeNormal);
    send_item(OpTick, 1'b0, 14'd0, ModeNormal);
    send_item(OpReqShutdown, 1'b1, 14'd16383, ModeUnusedHigh);
    send_item(OpSetMode, 1'b0, 14'd0, ModeShutdown);
    send_item(OpSetMode, 1'b0, 14'd0, ModeNormal);
    send_item(OpForceShutdown, 1'b1, 14'd16383, ModeUnusedHigh);

    // Random phases. Each one writes a fresh set of registers while the
    // block is idle and picks its own idling pattern, so both sides run with
    // and without gaps. Most phases use short intervals so that captures,
    // blinks and long presses come often; a few hold the extremes.
    for (ph = 0; ph < 8; ph++) begin
      drain();
      tx_idle = (ph % 2) == 1;
      rx_idle = ((ph / 2) % 2) == 1;
      case (ph)
        2: begin
          lo = 16'd16383; crit = 16'd16383;
          ivl = 16'hFFFF; per = 16'hFFFF; lit = 16'hFFFF; lp = 16'hFFFF;
        end
        5: begin
          lo = 16'd0; crit = 16'd0;
          ivl = 16'd1; per = 16'd1; lit = 16'd0; lp = 16'd1;
        end
        6: begin
          // Zero intervals: capture on every tick, the green lamp lights on
          // every standby tick, and a press latches on its second held tick.
          lo = 16'($urandom_range(6200, 8200)); crit = 16'($urandom_range(5800, 7000));
          ivl = 16'd0; per = 16'd0; lit = 16'd0; lp = 16'd0;
        end
        default: begin
          lo   = 16'($urandom_range(6200, 8200));
          crit = 16'($urandom_range(5800, lo));
          ivl  = 16'($urandom_range(1, 6));
          per  = 16'($urandom_range(1, 10));
          lit  = 16'($urandom_range(0, 12));
          lp   = 16'($urandom_range(1, 8));
        end
      endcase
      load_settings(lo, crit, ivl, per, lit, lp);

      for (n = 0; n < 240; n++) begin
        r = $urandom_range(0, 99);
        if (r < 72) op = OpTick;
        else if (r < 90) op = OpSetMode;
        else if (r < 95) op = OpReqShutdown;
        else op = OpForceShutdown;

        // The button is held in runs so that long presses happen.
        if ($urandom_range(0, 4) == 0) held = ~held;

        // Mostly readings around the thresholds, sometimes anywhere.
        if ($urandom_range(0, 3) == 0) mv = 14'($urandom_range(0, 16383));
        else mv = 14'($urandom_range(6200, 8600));

        r = $urandom_range(0, 9);
        nm = (r < 8) ? 3'(r % 5) : 3'($urandom_range(5, 7));

        if (op == OpTick) send_item(op, held, mv, nm);
        else send_item(op, 1'($urandom_range(0, 1)), mv, nm);
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (fails == 0) begin
      $display("battery_power_supervisor: match");
    end else begin
      $display("battery_power_supervisor: mismatch");
    end
    $finish;
  end

endmodule
